@@ sv/kscv_pkg.sv @@
// kscv_pkg: shared types and constants for the plucked-string clang voice.
// Used by the channel interfaces and the voice top level; no dependencies.
package kscv_pkg;

    // Result sample width (Q1.15) and configuration port shape
    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RING     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED     = 2'd3;

    // Configuration widths and reset values
    localparam int FB_W    = 16;
    localparam int AMP_W   = 24;
    localparam int RING_W  = 18;
    localparam int NOISE_W = 32;
    localparam logic [FB_W-1:0]    FB_RST    = 16'd65012;
    localparam logic [AMP_W-1:0]   DECAY_RST = 24'd16776545;
    localparam logic [RING_W-1:0]  RING_RST  = 18'd176400;
    localparam logic [NOISE_W-1:0] SEED_RST  = 32'd3237998097;

    // LCG noise generator
    localparam logic [NOISE_W-1:0] LCG_A = 32'd1664525;
    localparam logic [NOISE_W-1:0] LCG_C = 32'd1013904223;

    // Voice constants: start amplitude 0.55 (Q0.24), output gain 0.45 (Q0.16)
    localparam logic [AMP_W-1:0] START_AMP = 24'd9227469;
    localparam logic [15:0]      OUT_GAIN  = 16'd29491;

    // Shared multiplier: signed operands, wide enough for a 32-bit unsigned LCG state
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Saturating rational tanh: drive magnitude, square, denominator, quotient
    localparam int M_W   = 17;
    localparam int X2_W  = 19;
    localparam int NUM_W = 21;
    localparam int DEN_W = 22;
    localparam int Q_W   = 17;
    localparam logic [M_W-1:0]   TANH_KNEE = 17'd98304;
    localparam logic [DEN_W-1:0] TANH_A    = 22'd884736;
    localparam logic [Q_W-1:0]   ONE_Q15   = 17'd32768;

endpackage

@@ sv/kscv_if.sv @@
// kscv_if: valid/ready channel interfaces for the clang voice.
// Input beats carry op and trigger_pan; output beats carry sample and channel.
// Depends on kscv_pkg for the sample width.
interface kscv_in_if;
    logic valid;
    logic ready;
    logic op;
    logic trigger_pan;

    modport source (output valid, output op, output trigger_pan, input ready);
    modport sink   (input valid, input op, input trigger_pan, output ready);
endinterface

interface kscv_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [kscv_pkg::SAMPLE_W-1:0] sample;
    logic                                channel;

    modport source (output valid, output sample, output channel, input ready);
    modport sink   (input valid, input sample, input channel, output ready);
endinterface

@@ sv/karplus_strong_clang_voice.sv @@
// karplus_strong_clang_voice: one-shot plucked-string voice with soft-clipped output.
// Depends on kscv_pkg (constants) and kscv_if.sv (channel interfaces).
//
//   channel   dir   beat                         notes
//   i_in      in    op, trigger_pan              op 1 = trigger, op 0 = tick
//   o_out     out   sample (Q1.15), channel      one beat per tick, none per trigger
//   i_cfg_*   in    we, idx, data                write-only register port
//
// On a trigger the LCG fills the delay line, one slot a cycle.
// A ringing tick is stepped by the sequencer through one shared 33x33 multiplier and a
// 17-step restoring divider for the tanh; the divider is skipped when the drive
// reaches the tanh knee. A silent tick goes from idle straight to the emit state.
// The input is ready only while the sequencer idles; a held result in the output
// register does not block acceptance, only the final load of the next result.
// Synchronous active-low reset; the delay line needs no clearing pass.
module karplus_strong_clang_voice #(
    parameter int DELAY_LEN   = 800,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    kscv_in_if.sink                           i_in,
    kscv_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [kscv_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kscv_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int AW     = (DELAY_LEN > 1) ? $clog2(DELAY_LEN) : 1;
    localparam int SB     = SAMPLE_BITS;
    localparam int DRV_SH = SAMPLE_BITS + 9;
    localparam int CNT_W  = $clog2(kscv_pkg::Q_W);
    localparam logic [AW-1:0] LAST_IDX = AW'(DELAY_LEN - 1);

    typedef enum logic [13:0] {
        ST_IDLE  = 14'h0001,
        ST_FILL  = 14'h0002,
        ST_RDR   = 14'h0004,
        ST_AVG   = 14'h0008,
        ST_WB    = 14'h0010,
        ST_DEC   = 14'h0020,
        ST_MAG   = 14'h0040,
        ST_SQR   = 14'h0080,
        ST_NUM   = 14'h0100,
        ST_DIVST = 14'h0200,
        ST_DIV   = 14'h0400,
        ST_GAIN  = 14'h0800,
        ST_RND   = 14'h1000,
        ST_EMIT  = 14'h2000
    } t_state;

    // Control registers
    t_state                          r_state, n_state;
    logic [kscv_pkg::FB_W-1:0]       r_fb, n_fb;
    logic [kscv_pkg::AMP_W-1:0]      r_decay, n_decay;
    logic [kscv_pkg::RING_W-1:0]     r_ring_len, n_ring_len;
    logic [kscv_pkg::NOISE_W-1:0]    r_noise, n_noise;
    logic [kscv_pkg::AMP_W-1:0]      r_amp, n_amp;
    logic [kscv_pkg::RING_W-1:0]     r_ring, n_ring;
    logic                            r_pan, n_pan;
    logic [AW-1:0]                   r_widx, n_widx;
    logic [AW-1:0]                   r_idx, n_idx;
    logic [CNT_W-1:0]                r_cnt, n_cnt;
    logic                            r_out_valid, n_out_valid;

    // Datapath registers
    logic signed [SB-1:0]                  r_dline [DELAY_LEN];
    logic signed [SB-1:0]                  r_rd;
    logic signed [SB-1:0]                  r_s;
    logic [AW-1:0]                         r_ridx;
    logic signed [kscv_pkg::PROD_W-1:0]    r_prod;
    logic [kscv_pkg::M_W-1:0]              r_m;
    logic                                  r_neg;
    logic [kscv_pkg::DEN_W-1:0]            r_den;
    logic [kscv_pkg::DEN_W-1:0]            r_rem;
    logic [kscv_pkg::Q_W-1:0]              r_dq;
    logic [kscv_pkg::SAMPLE_W-1:0]         r_res;
    logic [kscv_pkg::SAMPLE_W-1:0]         r_out_sample;
    logic                                  r_out_channel;

    // Combinational signals
    logic                                  in_fire;
    logic                                  out_take;
    logic                                  emit_ok;
    logic signed [kscv_pkg::MUL_W-1:0]     mul_a;
    logic signed [kscv_pkg::MUL_W-1:0]     mul_b;
    logic signed [kscv_pkg::PROD_W-1:0]    mul_p;
    logic [kscv_pkg::NOISE_W-1:0]          lcg_next;
    logic signed [SB-1:0]                  noise;
    logic signed [SB:0]                    pair_sum;
    logic signed [SB-1:0]                  avg;
    logic signed [kscv_pkg::PROD_W-1:0]    prod_rnd;
    logic [kscv_pkg::AMP_W-1:0]            amp_new;
    logic [kscv_pkg::PROD_W-1:0]           abs_p;
    logic [kscv_pkg::PROD_W+2:0]           abs_p7;
    logic [kscv_pkg::X2_W-1:0]             x2;
    logic [kscv_pkg::NUM_W-1:0]            num_fac;
    logic [kscv_pkg::DEN_W-1:0]            den;
    logic [kscv_pkg::DEN_W:0]              trial;
    logic                                  trial_ge;
    logic [kscv_pkg::DEN_W:0]              trial_sub;
    logic [kscv_pkg::Q_W-1:0]              o_mag;
    logic [kscv_pkg::Q_W-1:0]              o_sgn;
    logic [AW-1:0]                         next_idx;
    logic                                  mem_we;
    logic [AW-1:0]                         mem_waddr;
    logic signed [SB-1:0]                  mem_wdata;
    logic                                  mem_re;
    logic [AW-1:0]                         mem_raddr;

    // Handshakes
    assign i_in.ready    = (r_state == ST_IDLE);
    assign in_fire       = i_in.valid && (r_state == ST_IDLE);
    assign out_take      = r_out_valid && o_out.ready;
    assign emit_ok       = !r_out_valid || o_out.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.sample  = r_out_sample;
    assign o_out.channel = r_out_channel;

    // Select operands of the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_FILL: begin
                mul_a = kscv_pkg::MUL_W'(r_noise);
                mul_b = kscv_pkg::MUL_W'(kscv_pkg::LCG_A);
            end
            ST_AVG: begin
                mul_a = kscv_pkg::MUL_W'(avg);
                mul_b = kscv_pkg::MUL_W'(r_fb);
            end
            ST_WB: begin
                mul_a = kscv_pkg::MUL_W'(r_amp);
                mul_b = kscv_pkg::MUL_W'(r_decay);
            end
            ST_DEC: begin
                mul_a = kscv_pkg::MUL_W'(r_s);
                mul_b = kscv_pkg::MUL_W'(amp_new);
            end
            ST_SQR: begin
                mul_a = kscv_pkg::MUL_W'(r_m);
                mul_b = kscv_pkg::MUL_W'(r_m);
            end
            ST_NUM: begin
                mul_a = kscv_pkg::MUL_W'(r_m);
                mul_b = kscv_pkg::MUL_W'(num_fac);
            end
            ST_GAIN: begin
                mul_a = kscv_pkg::MUL_W'(r_dq);
                mul_b = kscv_pkg::MUL_W'(kscv_pkg::OUT_GAIN);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Noise: advance the LCG, keep its top bits as a half-scale sample
    assign lcg_next = mul_p[kscv_pkg::NOISE_W-1:0] + kscv_pkg::LCG_C;
    assign noise    = {lcg_next[kscv_pkg::NOISE_W-1],
                       lcg_next[kscv_pkg::NOISE_W-1 -: SB-1]};

    // Loop filter: floor average, then rounded feedback scale
    assign pair_sum = (SB+1)'(r_s) + (SB+1)'(r_rd);
    assign avg      = pair_sum[SB:1];
    assign prod_rnd = r_prod + kscv_pkg::PROD_W'(32768);
    assign amp_new  = r_prod[kscv_pkg::AMP_W +: kscv_pkg::AMP_W];

    // Drive magnitude of 3.5 * sample * amplitude in Q.15
    assign abs_p  = r_prod[kscv_pkg::PROD_W-1] ? kscv_pkg::PROD_W'(-r_prod)
                                               : kscv_pkg::PROD_W'(r_prod);
    assign abs_p7 = {abs_p, 3'b000} - {3'b000, abs_p};

    // Rational tanh terms from the registered square
    assign x2      = r_prod[15 +: kscv_pkg::X2_W];
    assign num_fac = kscv_pkg::NUM_W'(kscv_pkg::TANH_A) + kscv_pkg::NUM_W'(x2);
    assign den     = kscv_pkg::TANH_A + kscv_pkg::DEN_W'({x2, 3'b000})
                   + kscv_pkg::DEN_W'(x2);

    // Restoring divider step: one quotient bit a cycle
    assign trial     = {r_rem, r_dq[kscv_pkg::Q_W-1]};
    assign trial_ge  = (trial >= {1'b0, r_den});
    assign trial_sub = trial - {1'b0, r_den};

    // Output rounding and sign
    assign o_mag = prod_rnd[16 +: kscv_pkg::Q_W];
    assign o_sgn = r_neg ? (~o_mag + kscv_pkg::Q_W'(1)) : o_mag;

    assign next_idx = (r_widx == LAST_IDX) ? '0 : r_widx + AW'(1);

    // Delay-line port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_widx;
        mem_wdata = prod_rnd[16 +: SB];
        mem_re    = 1'b0;
        mem_raddr = r_widx;
        case (r_state)
            ST_IDLE: begin
                mem_re = in_fire && !i_in.op && (r_ring != '0);
            end
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = noise;
            end
            ST_RDR: begin
                mem_re    = 1'b1;
                mem_raddr = r_ridx;
            end
            ST_WB: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
                mem_re = 1'b0;
            end
        endcase
    end

    // Sequencer and control state
    always_comb begin
        n_state     = r_state;
        n_fb        = r_fb;
        n_decay     = r_decay;
        n_ring_len  = r_ring_len;
        n_noise     = r_noise;
        n_amp       = r_amp;
        n_ring      = r_ring;
        n_pan       = r_pan;
        n_widx      = r_widx;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_out_valid = out_take ? 1'b0 : r_out_valid;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in.op) begin
                        n_idx   = '0;
                        n_widx  = '0;
                        n_amp   = kscv_pkg::START_AMP;
                        n_ring  = r_ring_len;
                        n_pan   = i_in.trigger_pan;
                        n_state = ST_FILL;
                    end else if (r_ring != '0) begin
                        n_state = ST_RDR;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_FILL: begin
                n_noise = lcg_next;
                n_idx   = r_idx + AW'(1);
                if (r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RDR:   n_state = ST_AVG;
            ST_AVG:   n_state = ST_WB;
            ST_WB: begin
                n_widx  = r_ridx;
                n_ring  = r_ring - kscv_pkg::RING_W'(1);
                n_state = ST_DEC;
            end
            ST_DEC: begin
                n_amp   = amp_new;
                n_state = ST_MAG;
            end
            ST_MAG:   n_state = ST_SQR;
            ST_SQR: begin
                n_state = (r_m >= kscv_pkg::TANH_KNEE) ? ST_GAIN : ST_NUM;
            end
            ST_NUM:   n_state = ST_DIVST;
            ST_DIVST: begin
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(kscv_pkg::Q_W - 1)) begin
                    n_state = ST_GAIN;
                end
            end
            ST_GAIN:  n_state = ST_RND;
            ST_RND:   n_state = ST_EMIT;
            ST_EMIT: begin
                if (emit_ok) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase

        // Apply configuration writes; the user must issue them only while idle, the block does not enforce it
        if (i_cfg_we) begin
            case (i_cfg_idx)
                kscv_pkg::REG_FEEDBACK: n_fb       = i_cfg_data[kscv_pkg::FB_W-1:0];
                kscv_pkg::REG_DECAY:    n_decay    = i_cfg_data[kscv_pkg::AMP_W-1:0];
                kscv_pkg::REG_RING:     n_ring_len = i_cfg_data[kscv_pkg::RING_W-1:0];
                kscv_pkg::REG_SEED:     n_noise    = i_cfg_data[kscv_pkg::NOISE_W-1:0];
                default:                n_fb       = r_fb;
            endcase
        end
    end

    // Control registers with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fb        <= kscv_pkg::FB_RST;
            r_decay     <= kscv_pkg::DECAY_RST;
            r_ring_len  <= kscv_pkg::RING_RST;
            r_noise     <= kscv_pkg::SEED_RST;
            r_amp       <= '0;
            r_ring      <= '0;
            r_pan       <= 1'b0;
            r_widx      <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fb        <= n_fb;
            r_decay     <= n_decay;
            r_ring_len  <= n_ring_len;
            r_noise     <= n_noise;
            r_amp       <= n_amp;
            r_ring      <= n_ring;
            r_pan       <= n_pan;
            r_widx      <= n_widx;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Delay-line memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_dline[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_dline[mem_raddr];
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            ST_IDLE: begin
                r_ridx <= next_idx;
                r_res  <= '0;
            end
            ST_RDR: begin
                r_s <= r_rd;
            end
            ST_MAG: begin
                r_m   <= abs_p7[DRV_SH +: kscv_pkg::M_W];
                r_neg <= r_prod[kscv_pkg::PROD_W-1];
            end
            ST_SQR: begin
                r_dq <= kscv_pkg::ONE_Q15;
            end
            ST_NUM: begin
                r_den <= den;
            end
            ST_DIVST: begin
                r_rem <= r_prod[kscv_pkg::Q_W +: kscv_pkg::DEN_W];
                r_dq  <= r_prod[kscv_pkg::Q_W-1:0];
            end
            ST_DIV: begin
                r_rem <= trial_ge ? trial_sub[kscv_pkg::DEN_W-1:0]
                                  : trial[kscv_pkg::DEN_W-1:0];
                r_dq  <= {r_dq[kscv_pkg::Q_W-2:0], trial_ge};
            end
            ST_RND: begin
                r_res <= o_sgn[kscv_pkg::SAMPLE_W-1:0];
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    r_out_sample  <= r_res;
                    r_out_channel <= r_pan;
                end
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

endmodule

@@ sv/kscv_chk.sv @@
// kscv_chk: port-level assertions for the clang voice, bound to the top level.
// Sees only the top-level ports; depends on kscv_pkg for the sample width.
module kscv_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_in_op,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [kscv_pkg::SAMPLE_W-1:0]       i_out_sample,
    input logic                                i_out_channel
);

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_sample) && $stable(i_out_channel))
        else $error("output beat dropped or changed while stalled");

    // Drop ready after every accepted input beat: one item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted on back-to-back cycles");

    // Clear the output after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A trigger yields no result right away
    a_trig_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_op |=> !$rose(i_out_valid))
        else $error("result raised right after a trigger");

endmodule

bind karplus_strong_clang_voice kscv_chk u_kscv_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_op      (i_in.op),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample),
    .i_out_channel(o_out.channel)
);
